// ===== sv/cppu_pkg.sv =====
package cppu_pkg;

    localparam int L_COUNT_DEF   = 64;
    localparam int FRAC_BITS_DEF = 22;
    localparam int IN_W    = 24;
    localparam int MAG_W   = 24;
    localparam int PH_W    = 32;
    localparam int SUM_W   = 32;
    localparam int L_W     = 6;
    localparam int ANG_W   = 36;
    localparam int CW      = 56;
    localparam int ITERS   = 31;
    localparam int IT_W    = 5;
    localparam int SQ_W    = 48;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PHASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_SUMS   = 1'b1;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_CORDIC, S_ROUND, S_DIFF, S_UNWRAP, S_SAT,
        S_RDSUM, S_ACC, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sq;
        logic root_step;
        logic cordic_step;
        logic round;
        logic diff;
        logic unwrap;
        logic sat;
        logic rdsum;
        logic acc;
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic cordic_done;
        logic k_done;
    } t_sts;

    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [IT_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:  r = 36'h03243F6A8;
            5'd1:  r = 36'h01DAC6705;
            5'd2:  r = 36'h00FADBAFC;
            5'd3:  r = 36'h007F56EA6;
            5'd4:  r = 36'h003FEAB76;
            5'd5:  r = 36'h001FFD55B;
            5'd6:  r = 36'h000FFFAAA;
            5'd7:  r = 36'h0007FFF55;
            5'd8:  r = 36'h0003FFFEA;
            5'd9:  r = 36'h0001FFFFD;
            5'd10: r = 36'h0000FFFFF;
            5'd11: r = 36'h00007FFFF;
            5'd12: r = 36'h00003FFFF;
            5'd13: r = 36'h00001FFFF;
            5'd14: r = 36'h00000FFFF;
            5'd15: r = 36'h000007FFF;
            5'd16: r = 36'h000003FFF;
            5'd17: r = 36'h000001FFF;
            5'd18: r = 36'h000000FFF;
            5'd19: r = 36'h0000007FF;
            5'd20: r = 36'h0000003FF;
            5'd21: r = 36'h0000001FF;
            5'd22: r = 36'h0000000FF;
            5'd23: r = 36'h00000007F;
            5'd24: r = 36'h00000003F;
            5'd25: r = 36'h00000001F;
            5'd26: r = 36'h00000000F;
            5'd27: r = 36'h000000008;
            5'd28: r = 36'h000000004;
            5'd29: r = 36'h000000002;
            5'd30: r = 36'h000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/cppu_if.sv =====
interface cppu_in_if;
    import cppu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  s_real;
    logic signed [IN_W-1:0]  s_imag;
    logic [L_W-1:0]          l_index;
    logic                    first_of_sweep;
    modport source (output valid, s_real, s_imag, l_index, first_of_sweep, input ready);
    modport sink   (input valid, s_real, s_imag, l_index, first_of_sweep, output ready);
endinterface

interface cppu_out_if;
    import cppu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [MAG_W-1:0]        magnitude;
    logic signed [PH_W-1:0]  phase_out;
    logic                    phase_valid;
    logic [SUM_W-1:0]        unitarity_sum;
    modport source (output valid, magnitude, phase_out, phase_valid, unitarity_sum,
                    input ready);
    modport sink   (input valid, magnitude, phase_out, phase_valid, unitarity_sum,
                    output ready);
endinterface

// ===== sv/cppu_ctrl.sv =====
module cppu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  cppu_pkg::t_sts  i_sts,
    output cppu_pkg::t_cmd  o_cmd
);
    import cppu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step   = 1'b1;
                o_cmd.cordic_step = 1'b1;
                if (i_sts.root_done && i_sts.cordic_done) n_state = S_ROUND;
                else if (i_sts.root_done) n_state = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.cordic_done) n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_UNWRAP;
            end
            S_UNWRAP: begin
                o_cmd.unwrap = 1'b1;
                if (i_sts.k_done) n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state = S_RDSUM;
            end
            S_RDSUM: begin
                o_cmd.rdsum = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = S_SQ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/cppu_dp.sv =====
module cppu_dp #(
    parameter int L_COUNT   = cppu_pkg::L_COUNT_DEF,
    parameter int FRAC_BITS = cppu_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cppu_pkg::t_cmd                    i_cmd,
    output cppu_pkg::t_sts                    o_sts,
    input  logic                              i_half_phase,
    input  logic                              i_acc_sums,
    input  logic signed [cppu_pkg::IN_W-1:0]  i_s_real,
    input  logic signed [cppu_pkg::IN_W-1:0]  i_s_imag,
    input  logic [cppu_pkg::L_W-1:0]          i_l_index,
    input  logic                              i_first,
    output logic [cppu_pkg::MAG_W-1:0]        o_magnitude,
    output logic signed [cppu_pkg::PH_W-1:0]  o_phase_out,
    output logic                              o_phase_valid,
    output logic [cppu_pkg::SUM_W-1:0]        o_unitarity_sum
);
    import cppu_pkg::*;

    localparam int SH = 30 - FRAC_BITS;
    localparam int AW = $clog2(L_COUNT);
    localparam int UW = 40;
    localparam logic signed [ANG_W-1:0] HALF_RND = ANG_W'(1) <<< (SH - 1);
    localparam logic signed [UW-1:0] TP =
        UW'((TWO_PI_Q30 + HALF_RND) >>> SH);

    logic signed [IN_W-1:0] r_re, r_im;
    logic [L_W-1:0]         r_l;
    logic                   r_first;
    logic [SQ_W-1:0]        r_sq;
    logic [SQ_W-1:0]        r_rem;
    logic [MAG_W:0]         r_root;
    logic [4:0]             r_rit;
    logic signed [CW-1:0]   r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [IT_W-1:0]        r_cit;
    logic                   r_cdone;
    logic signed [UW-1:0]   r_prev, r_a, r_d;
    logic signed [UW-1:0]   r_u;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_mem [L_COUNT];
    logic [L_COUNT-1:0]     r_vld;
    logic [MAG_W-1:0]       r_mag;
    logic signed [PH_W-1:0] r_ph;
    logic                   r_pv;
    logic [SUM_W-1:0]       r_osum;

    logic                   w_inrange;
    logic [AW-1:0]          w_addr;
    logic                   w_valid;
    logic signed [CW-1:0]   w_dx, w_dy;
    logic [SQ_W-1:0]        w_trial;
    logic signed [ANG_W-1:0] w_ar;

    assign w_inrange = {{(32-L_W){1'b0}}, r_l} < 32'(L_COUNT);
    assign w_addr    = AW'(r_l);
    assign w_valid   = r_sq != '0;
    assign w_dx = r_y >>> r_cit;
    assign w_dy = r_x >>> r_cit;
    assign w_trial = (SQ_W'(r_root) << {r_rit, 1'b0}) +
                     (SQ_W'(1) << ({r_rit, 1'b0} - 6'd2));
    assign w_ar = (r_z + HALF_RND) >>> SH;

    assign o_sts.root_done   = r_rit == 5'd0;
    assign o_sts.cordic_done = r_cdone;
    assign o_sts.k_done      = (r_d <= (TP >>> 1)) && (r_d >= -(TP >>> 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re <= i_s_real;
            r_im <= i_s_imag;
            r_l  <= i_l_index;
            r_first <= i_first;
        end
        if (i_cmd.sq) begin
            r_sq  <= SQ_W'(r_re * r_re) + SQ_W'(r_im * r_im);
            r_rem <= SQ_W'(r_re * r_re) + SQ_W'(r_im * r_im);
            r_root <= '0;
            r_rit <= 5'd24;
            r_cit <= '0;
            r_cdone <= (r_im == '0) || (r_re == '0);
            if (r_im == '0) begin
                r_z <= (r_re < 0) ? PI_Q30 : '0;
            end else if (r_re == '0) begin
                r_z <= (r_im > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
            end else if (r_re < 0) begin
                if (r_im > 0) begin
                    r_x <= CW'(r_im) <<< 28;
                    r_y <= -(CW'(r_re) <<< 28);
                    r_z <= HALF_PI_Q30;
                end else begin
                    r_x <= -(CW'(r_im) <<< 28);
                    r_y <= CW'(r_re) <<< 28;
                    r_z <= -HALF_PI_Q30;
                end
            end else begin
                r_x <= CW'(r_re) <<< 28;
                r_y <= CW'(r_im) <<< 28;
                r_z <= '0;
            end
        end
        // restoring square root, one result bit per beat
        if (i_cmd.root_step && !o_sts.root_done) begin
            r_rit <= r_rit - 5'd1;
            if (r_rem >= w_trial) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root << 1) | (MAG_W+1)'(1);
            end else begin
                r_root <= r_root << 1;
            end
        end
        if (i_cmd.cordic_step && !r_cdone) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + atan_tab(r_cit);
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - atan_tab(r_cit);
            end
            r_cit <= r_cit + 1'b1;
            if (r_cit == IT_W'(ITERS - 1)) r_cdone <= 1'b1;
        end
        if (i_cmd.round) begin
            r_a <= UW'(w_ar);
        end
        if (i_cmd.diff) begin
            r_d <= r_a - (r_first ? UW'(0) : r_prev);
        end
        // ties toward zero: reduce while |d| is above half a turn
        if (i_cmd.unwrap && !o_sts.k_done) begin
            r_d <= (r_d > 0) ? r_d - TP : r_d + TP;
        end
        if (i_cmd.unwrap && o_sts.k_done) begin
            r_u <= r_a - r_a + (r_first ? UW'(0) : r_prev) + r_d;
        end
        if (i_cmd.sat) begin
            r_mag <= r_root[MAG_W] ? {MAG_W{1'b1}} : r_root[MAG_W-1:0];
            r_pv  <= w_valid;
            if (!w_valid) r_ph <= '0;
            else begin
                logic signed [PH_W-1:0] v;
                v = (r_u > UW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                    (r_u < -UW'(33'sh80000000)) ? 32'sh80000000 : PH_W'(r_u);
                r_ph <= i_half_phase ? (v >>> 1) : v;
            end
        end
        if (i_cmd.rdsum) begin
            r_sum <= r_vld[w_addr] ? r_mem[w_addr] : '0;
        end
        if (i_cmd.acc) begin
            logic [SUM_W:0] s;
            s = {1'b0, r_sum} + (SUM_W+1)'(r_sq >> FRAC_BITS);
            if (w_inrange && i_acc_sums && w_valid) begin
                r_mem[w_addr] <= s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
                r_osum <= s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
            end else begin
                r_osum <= w_inrange ? r_sum : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_vld  <= '0;
        end else begin
            if (i_cmd.diff && r_first) r_prev <= '0;
            if (i_cmd.sat && w_valid) begin
                r_prev <= (r_u > UW'(32'sh7FFFFFFF)) ? UW'(32'sh7FFFFFFF) :
                          (r_u < -UW'(33'sh80000000)) ? -UW'(33'sh80000000) : r_u;
            end
            if (i_cmd.acc && w_inrange && i_acc_sums && w_valid) r_vld[w_addr] <= 1'b1;
        end
    end

    assign o_magnitude     = r_mag;
    assign o_phase_out     = r_ph;
    assign o_phase_valid   = r_pv;
    assign o_unitarity_sum = r_osum;
endmodule

// ===== sv/complex_polar_phase_unwrap.sv =====
// complex polar conversion with phase unwrap
// in channel: one beat carries s_real, s_imag (Q1.22), l_index and first_of_sweep
// out channel: one beat per input beat with magnitude, phase_out, phase_valid and
// unitarity_sum
// config port: i_cfg_we, i_cfg_idx (0 half_phase, 1 accumulate_sums), i_cfg_data
// one item at a time: after accept the item passes one squaring beat, the square
// root run alongside the 31-step cordic vectoring loop, rounding, the difference,
// the unwrap loop, which removes one full turn per step, saturation and the sum
// read-modify-write; the unwrap loop removes none when the new angle is near the
// previous phase and up to 82 when the previous phase sits far out toward the
// saturation limit; throughput is one item per result beat
// the next item is taken in the same cycle the result beat is taken
// reset clears the state machine, the previous phase, the config registers and the
// valid bits of the per-l sum store, so all sums read as zero
// when the receiver stalls the result is held and no new item is accepted
module complex_polar_phase_unwrap #(
    parameter int L_COUNT   = cppu_pkg::L_COUNT_DEF,
    parameter int FRAC_BITS = cppu_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cppu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic                             i_cfg_data,
    cppu_in_if.sink                          s_in,
    cppu_out_if.source                       m_out
);
    import cppu_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic r_half, r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
            r_acc  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALF_PHASE: r_half <= i_cfg_data;
                REG_ACC_SUMS:   r_acc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cppu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_in.valid),
        .o_in_ready (s_in.ready),
        .o_out_valid(m_out.valid),
        .i_out_ready(m_out.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cppu_dp #(.L_COUNT(L_COUNT), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_half_phase   (r_half),
        .i_acc_sums     (r_acc),
        .i_s_real       (s_in.s_real),
        .i_s_imag       (s_in.s_imag),
        .i_l_index      (s_in.l_index),
        .i_first        (s_in.first_of_sweep),
        .o_magnitude    (m_out.magnitude),
        .o_phase_out    (m_out.phase_out),
        .o_phase_valid  (m_out.phase_valid),
        .o_unitarity_sum(m_out.unitarity_sum)
    );
endmodule

// ===== sv/cppu_chk.sv =====
module cppu_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_phase_valid,
    input logic [31:0] i_phase_out,
    input logic [23:0] i_magnitude
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("out beat dropped");
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready) else $error("accept during stall");
    a_no_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid) else $error("result too early");
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_phase_valid |-> i_phase_out == '0 && i_magnitude == '0)
        else $error("phase on zero element");
endmodule

bind complex_polar_phase_unwrap cppu_chk u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_phase_valid(m_out.phase_valid), .i_phase_out(m_out.phase_out),
    .i_magnitude(m_out.magnitude)
);

// ===== dv/complex_polar_phase_unwrap_checker.sv =====
module complex_polar_phase_unwrap_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cppu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                           i_cfg_data,
    cppu_in_if.sink                        s_in,
    cppu_out_if.sink                       s_out,
    output int                             o_errors,
    output int                             o_pending
);
    import cppu_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0]       magnitude;
        logic signed [PH_W-1:0] phase_out;
        logic                   phase_valid;
        logic [SUM_W-1:0]       unitarity_sum;
    } t_polar;

    localparam int FB = FRAC_BITS_DEF;

    t_polar         polar_q[$];
    logic           half_q;
    logic           acc_q;
    longint         prev_phase;
    logic [31:0]    sums[L_COUNT_DEF];
    longint         atan_q30[ITERS];

    assign o_pending = polar_q.size();

    initial begin
        for (int i = 0; i < ITERS; i++) begin
            atan_q30[i] = longint'(atan_tab(IT_W'(i)));
        end
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint angle_q30(longint x, longint y);
        longint z, t, dx, dy;
        z = 0;
        if (y == 0) return (x < 0) ? longint'(PI_Q30) : 0;
        if (x == 0) return (y > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
        if (x < 0) begin
            if (y > 0) begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end else begin
                t = x; x = -y; y = t; z = -longint'(HALF_PI_Q30);
            end
        end
        x = x <<< 28;
        y = y <<< 28;
        for (int i = 0; i < ITERS; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_q30[i];
            end else begin
                x -= dx; y += dy; z -= atan_q30[i];
            end
        end
        return z;
    endfunction

    function automatic longint to_frac(longint v);
        return fshr(v + (longint'(1) <<< (29 - FB)), 30 - FB);
    endfunction

    function automatic longint isqrt(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) <<< b)) * (r + (longint'(1) <<< b)) <= n)
                r += longint'(1) <<< b;
        end
        return r;
    endfunction

    task automatic predict_polar(logic signed [IN_W-1:0] re_in,
                                 logic signed [IN_W-1:0] im_in,
                                 logic [L_W-1:0] l, logic first);
        longint re, im, sq, mag, a, tp, d, k, u, s;
        t_polar p;
        re = re_in;
        im = im_in;
        p = '0;
        if (first) prev_phase = 0;
        sq = re * re + im * im;
        mag = isqrt(sq);
        if (mag > 64'hFFFFFF) mag = 64'hFFFFFF;
        p.magnitude = mag[MAG_W-1:0];
        p.phase_valid = (sq != 0);
        if (sq != 0) begin
            a = to_frac(angle_q30(re, im));
            tp = to_frac(longint'(TWO_PI_Q30));
            d = a - prev_phase;
            if (d >= 0) k = (2 * d + tp - 1) / (2 * tp);
            else k = -((-2 * d + tp - 1) / (2 * tp));
            u = prev_phase + d - k * tp;
            if (u > 64'sh7FFFFFFF) u = 64'sh7FFFFFFF;
            if (u < -64'sh80000000) u = -64'sh80000000;
            prev_phase = u;
            p.phase_out = half_q ? PH_W'(u >>> 1) : PH_W'(u);
            if (acc_q) begin
                s = longint'(sums[l]) + (sq >> FB);
                sums[l] = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
            end
        end
        p.unitarity_sum = sums[l];
        polar_q.push_back(p);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_polar w;
        if (!i_rst_n) begin
            half_q <= 1'b0;
            acc_q <= 1'b0;
            prev_phase = 0;
            foreach (sums[i]) sums[i] = '0;
            polar_q.delete();
        end else begin
            if (s_out.valid && s_out.ready) begin
                if (polar_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    w = polar_q.pop_front();
                    if (s_out.magnitude !== w.magnitude)
                        report_mismatch("magnitude", s_out.magnitude, w.magnitude);
                    if (s_out.phase_out !== w.phase_out)
                        report_mismatch("phase_out", s_out.phase_out, w.phase_out);
                    if (s_out.phase_valid !== w.phase_valid)
                        report_mismatch("phase_valid", s_out.phase_valid, w.phase_valid);
                    if (s_out.unitarity_sum !== w.unitarity_sum)
                        report_mismatch("unitarity_sum", s_out.unitarity_sum,
                                        w.unitarity_sum);
                end
            end
            if (s_in.valid && s_in.ready)
                predict_polar(s_in.s_real, s_in.s_imag, s_in.l_index, s_in.first_of_sweep);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HALF_PHASE) half_q <= i_cfg_data;
                else if (i_cfg_idx == REG_ACC_SUMS) acc_q <= i_cfg_data;
            end
        end
    end
endmodule

// ===== dv/complex_polar_phase_unwrap_test.sv =====
module complex_polar_phase_unwrap_test;
    import cppu_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_HALF_PHASE;
    logic                 cfg_data = 1'b0;
    int                   errors;
    int                   pending;
    logic                 calm = 1'b0;
    logic                 hold_off = 1'b0;
    int                   sweep_len = 0;

    cppu_in_if  in_ch();
    cppu_out_if out_ch();

    complex_polar_phase_unwrap i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    complex_polar_phase_unwrap_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .s_in(in_ch.sink), .s_out(out_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.s_real = '0;
        in_ch.s_imag = '0;
        in_ch.l_index = '0;
        in_ch.first_of_sweep = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im,
                             logic [L_W-1:0] l, logic first);
        while (!calm && $urandom_range(99) < 24) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.s_real <= re;
        in_ch.s_imag <= im;
        in_ch.l_index <= l;
        in_ch.first_of_sweep <= first;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic signed [IN_W-1:0] pick_part();
        case ($urandom_range(5))
            0: return IN_W'($urandom_range(3)) - 24'sd1;
            1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            2: return IN_W'($urandom_range(2000)) - 24'sd1000;
            default: return IN_W'($urandom());
        endcase
    endfunction

    task automatic random_phase(int n);
        logic first;
        for (int i = 0; i < n; i++) begin
            first = (sweep_len == 0);
            if (first) sweep_len = $urandom_range(40, 1);
            sweep_len--;
            if ($urandom_range(19) == 0) first = 1'($urandom_range(1));
            send_beat(pick_part(), pick_part(), L_W'($urandom()), first);
        end
    endtask

    initial begin
        logic signed [IN_W-1:0] ext[5];
        ext = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd1, -24'sd1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(REG_HALF_PHASE, 1'b0);
        write_reg(REG_ACC_SUMS, 1'b1);
        foreach (ext[a]) foreach (ext[b])
            send_beat(ext[a], ext[b], L_W'(a * 5 + b), a == 0 && b == 0);
        drain();
        write_reg(REG_HALF_PHASE, 1'b1);
        // spin around the circle to push the unwrap into saturation
        for (int i = 0; i < 400; i++)
            send_beat(i % 4 == 0 ? 24'sh400000 : (i % 4 == 2 ? -24'sh400000 : 24'sd0),
                      i % 4 == 1 ? -24'sh400000 : (i % 4 == 3 ? 24'sh400000 : 24'sd0),
                      6'd63, i == 0);
        random_phase(300);
        drain();
        write_reg(REG_ACC_SUMS, 1'b0);
        calm = 1'b1;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(200);
        join
        calm = 1'b0;
        drain();
        write_reg(REG_HALF_PHASE, 1'b0);
        write_reg(REG_ACC_SUMS, 1'b1);
        random_phase(700);
        drain();
        if (errors == 0) $display("[complex_polar_phase_unwrap] OK");
        else $display("[complex_polar_phase_unwrap] ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("[complex_polar_phase_unwrap] ERROR");
        $finish;
    end
endmodule
